[rtl/nxn_rgb_convolution_filter_defines.svh]
// Assertion macros used by the convolution filter checker
`ifndef NXN_RGB_CONVOLUTION_FILTER_DEFINES_SVH
`define NXN_RGB_CONVOLUTION_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define NRCF_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define NRCF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/nrcf_pkg.sv]
// Shared types, field layout and codes of the NxN RGB convolution filter
package nrcf_pkg;

   localparam int CH_W       = 8;
   localparam int PIX_W      = 3 * CH_W;
   localparam int COEF_W     = 16;
   localparam int FRAC_W     = 8;
   localparam int IDX_W      = 6;
   localparam int XY_W       = 10;
   localparam int CFG_W      = 11;
   localparam int KCFG_W     = 3;
   localparam int CSR_ADDR_W = 2;

   // Actions carried in the request tuser
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_SIZE  = 2'd2;

   localparam logic [CFG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_W-1:0]  HEIGHT_RESET = 11'd1024;
   localparam logic [KCFG_W-1:0] KSIZE_RESET  = 3'd3;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Request layout
   localparam int REQ_USER_W   = 2;
   localparam int USER_ACTION  = 0;
   localparam int USER_FRAME   = 1;
   localparam int REQ_IDX_LSB  = 0;
   localparam int REQ_COEF_LSB = REQ_IDX_LSB + IDX_W;
   localparam int REQ_PIX_LSB  = REQ_COEF_LSB + COEF_W;
   localparam int REQ_DATA_W   = 48;

   // Response layout
   localparam int RSP_X_LSB     = 0;
   localparam int RSP_Y_LSB     = RSP_X_LSB + XY_W;
   localparam int RSP_PIX_LSB   = RSP_Y_LSB + XY_W;
   localparam int RSP_ALPHA_LSB = RSP_PIX_LSB + PIX_W;
   localparam int RSP_DATA_W    = 56;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;

   typedef logic [PIX_W-1:0]         pix_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [RSP_DATA_W-1:0]    rsp_word_type;

endpackage

[rtl/nrcf_ram.sv]
// Generic single-port-write RAM with registered read
module nrcf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, read one entry every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/nxn_rgb_convolution_filter.sv]
// NxN RGB convolution filter over a raster pixel stream
//
//   channel  | dir | handshake             | content
//   req      | in  | req_tvalid/req_tready | coefficient load or pixel
//   rsp      | out | rsp_tvalid/rsp_tready | filtered interior pixel
//   csr      | in  | csr_we                | image width, height, kernel size
//
// One word per cycle while req_tready is high; a pixel's result passes
// through line store read, window shift, multiply, row sums, final sum and
// clamp before it reaches the output queue.
// The line store is MAX_KERNEL-1 banks of MAX_WIDTH pixels; each pixel reads
// every bank and writes one at its column in the cycle it is accepted.
// req_tready drops only when the eight-entry result queue plus results in
// flight would overflow, or while reset is high. Reset is synchronous and needs no clearing pass.
module nxn_rgb_convolution_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_KERNEL = 7
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // coef_index, coef_value, in_red, in_green, in_blue, zero pad
   input  logic [nrcf_pkg::REQ_DATA_W-1:0] req_tdata,
   // action, frame_start
   input  logic [nrcf_pkg::REQ_USER_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_x, out_y, out_red, out_green, out_blue, out_alpha, zero pad
   output logic [nrcf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [nrcf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [nrcf_pkg::CFG_W-1:0] csr_wdata
);

   localparam int ROW_SLOTS = MAX_KERNEL - 1;
   localparam int TAPS      = MAX_KERNEL * MAX_KERNEL;
   localparam int X_W       = $clog2(MAX_WIDTH);
   localparam int Y_W       = $clog2(MAX_HEIGHT);
   localparam int K_W       = $clog2(MAX_KERNEL + 1);
   localparam int SL_W      = $clog2(ROW_SLOTS);
   localparam int CI_W      = $clog2(TAPS);
   localparam int CW        = nrcf_pkg::CH_W;
   localparam int PW        = nrcf_pkg::PIX_W;
   localparam int COEFW     = nrcf_pkg::COEF_W;
   localparam int FRACW     = nrcf_pkg::FRAC_W;
   localparam int XYW       = nrcf_pkg::XY_W;
   localparam int CFGW      = nrcf_pkg::CFG_W;
   localparam int PROD_W    = CW + 1 + COEFW;
   localparam int Q_W       = COEFW;
   localparam int ROW_W     = Q_W + $clog2(MAX_KERNEL);
   localparam int SUM_W     = ROW_W + $clog2(MAX_KERNEL);
   localparam int PTR_W     = nrcf_pkg::FIFO_PTR_W;
   localparam int USED_W    = PTR_W + 2;
   localparam int PAD_W     = nrcf_pkg::RSP_DATA_W - nrcf_pkg::RSP_ALPHA_LSB - CW;

   // ---------------- configuration registers ----------------
   logic [CFGW-1:0]                 width_ff, height_ff;
   logic [nrcf_pkg::KCFG_W-1:0]     ksize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nrcf_pkg::WIDTH_RESET;
         height_ff <= nrcf_pkg::HEIGHT_RESET;
         ksize_ff  <= nrcf_pkg::KSIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            nrcf_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            nrcf_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            nrcf_pkg::CSR_KERNEL_SIZE:  ksize_ff  <= csr_wdata[nrcf_pkg::KCFG_W-1:0];
            default: ;
         endcase
      end
   end

   // effective dimensions and odd kernel side
   logic [X_W:0]   w_eff;
   logic [Y_W:0]   h_eff;
   logic [K_W-1:0] n_sat, n_eff;

   always_comb begin
      if (width_ff == '0) w_eff = (X_W+1)'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = (X_W+1)'(MAX_WIDTH);
      else w_eff = (X_W+1)'(width_ff);
      if (height_ff == '0) h_eff = (Y_W+1)'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = (Y_W+1)'(MAX_HEIGHT);
      else h_eff = (Y_W+1)'(height_ff);
      if (ksize_ff == '0) n_sat = K_W'(1);
      else if (32'(ksize_ff) > MAX_KERNEL) n_sat = K_W'(MAX_KERNEL);
      else n_sat = K_W'(ksize_ff);
      n_eff = n_sat[0] ? n_sat : n_sat - 1'b1;
   end

   // ---------------- input word ----------------
   logic                        req_frame, accept, pix_acc, load_acc;
   logic [nrcf_pkg::IDX_W-1:0]  req_idx;
   nrcf_pkg::coef_type          req_coef;
   nrcf_pkg::pix_type           req_pix;

   assign req_frame = req_tuser[nrcf_pkg::USER_FRAME];
   assign req_idx   = req_tdata[nrcf_pkg::REQ_IDX_LSB +: nrcf_pkg::IDX_W];
   assign req_coef  = req_tdata[nrcf_pkg::REQ_COEF_LSB +: COEFW];
   assign req_pix   = req_tdata[nrcf_pkg::REQ_PIX_LSB +: PW];
   assign accept    = req_tvalid && req_tready;
   assign pix_acc   = accept && (req_tuser[nrcf_pkg::USER_ACTION] == nrcf_pkg::ACT_PIXEL);
   assign load_acc  = accept && (req_tuser[nrcf_pkg::USER_ACTION] == nrcf_pkg::ACT_LOAD);

   // ---------------- raster position ----------------
   logic [X_W-1:0]  col_ff, col_in, x0, ox0;
   logic [Y_W-1:0]  row_ff, row_in, y0, oy0;
   logic [SL_W-1:0] slot_ff, slot_in, slot0;
   logic            emit0;

   assign x0    = req_frame ? '0 : col_ff;
   assign y0    = req_frame ? '0 : row_ff;
   assign slot0 = req_frame ? '0 : slot_ff;
   assign ox0   = x0 - X_W'(n_eff >> 1);
   assign oy0   = y0 - Y_W'(n_eff >> 1);
   assign emit0 = pix_acc && (32'(x0) >= 32'(n_eff) - 1) && (32'(y0) >= 32'(n_eff) - 1);

   // advance column, wrap to next row and frame
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (pix_acc) begin
         if (({1'b0, x0} + 1'b1) >= w_eff) begin
            col_in = '0;
            if (({1'b0, y0} + 1'b1) >= h_eff) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = y0 + 1'b1;
               slot_in = (slot0 == SL_W'(ROW_SLOTS - 1)) ? '0 : slot0 + 1'b1;
            end
         end else begin
            col_in  = x0 + 1'b1;
            row_in  = y0;
            slot_in = slot0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // ---------------- line store ----------------
   nrcf_pkg::pix_type line_rd [ROW_SLOTS];

   for (genvar b = 0; b < ROW_SLOTS; b++) begin : g_bank
      nrcf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line (
         .clock   (clock),
         .wr_en   (pix_acc && (slot0 == SL_W'(b))),
         .wr_addr (x0),
         .wr_data (req_pix),
         .rd_addr (x0),
         .rd_data (line_rd[b])
      );
   end

   // ---------------- stage 1: line store data arrives ----------------
   logic                       s1_pixel_ff, s1_load_ff, s1_emit_ff;
   logic [nrcf_pkg::IDX_W-1:0] s1_idx_ff;
   nrcf_pkg::coef_type         s1_coef_ff;
   nrcf_pkg::pix_type          s1_pix_ff;
   logic [Y_W-1:0]             s1_y_ff, s1_oy_ff;
   logic [X_W-1:0]             s1_ox_ff;
   logic [SL_W-1:0]            s1_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pixel_ff <= 1'b0;
         s1_load_ff  <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_pixel_ff <= pix_acc;
         s1_load_ff  <= load_acc;
         s1_emit_ff  <= emit0;
      end
      s1_idx_ff  <= req_idx;
      s1_coef_ff <= req_coef;
      s1_pix_ff  <= req_pix;
      s1_y_ff    <= y0;
      s1_slot_ff <= slot0;
      s1_ox_ff   <= ox0;
      s1_oy_ff   <= oy0;
   end

   // build the new window column: stored rows above, this pixel at the bottom
   nrcf_pkg::pix_type col_word [MAX_KERNEL];

   for (genvar r = 0; r < MAX_KERNEL; r++) begin : g_col
      logic [K_W-1:0] gap, bank;
      assign gap  = n_eff - K_W'(r + 1);
      assign bank = (K_W'(s1_slot_ff) >= gap) ? K_W'(s1_slot_ff) - gap
                                              : K_W'(s1_slot_ff) + K_W'(ROW_SLOTS) - gap;
      assign col_word[r] = (gap == '0) ? s1_pix_ff :
                           (32'(gap) > 32'(s1_y_ff)) ? '0 : line_rd[SL_W'(bank)];
   end

   // shift the active window left and insert the new column
   nrcf_pkg::pix_type win_ff [MAX_KERNEL][MAX_KERNEL];

   for (genvar r = 0; r < MAX_KERNEL; r++) begin : g_win_row
      for (genvar c = 0; c < MAX_KERNEL; c++) begin : g_win_col
         if (c < MAX_KERNEL - 1) begin : g_mid
            always_ff @(posedge clock) begin
               if (reset) begin
                  win_ff[r][c] <= '0;
               end else if (s1_pixel_ff && (K_W'(r) < n_eff)) begin
                  if (K_W'(c + 1) < n_eff) win_ff[r][c] <= win_ff[r][c+1];
                  else if (K_W'(c + 1) == n_eff) win_ff[r][c] <= col_word[r];
               end
            end
         end else begin : g_end
            always_ff @(posedge clock) begin
               if (reset) begin
                  win_ff[r][c] <= '0;
               end else if (s1_pixel_ff && (K_W'(r) < n_eff) && (K_W'(c + 1) == n_eff)) begin
                  win_ff[r][c] <= col_word[r];
               end
            end
         end
      end
   end

   // ---------------- stage 2: coefficient write, products ----------------
   logic                       s2_load_ff, s2_emit_ff;
   logic [nrcf_pkg::IDX_W-1:0] s2_idx_ff;
   nrcf_pkg::coef_type         s2_coef_ff;
   logic [X_W-1:0]             s2_ox_ff;
   logic [Y_W-1:0]             s2_oy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_load_ff <= 1'b0;
         s2_emit_ff <= 1'b0;
      end else begin
         s2_load_ff <= s1_load_ff;
         s2_emit_ff <= s1_emit_ff;
      end
      s2_idx_ff  <= s1_idx_ff;
      s2_coef_ff <= s1_coef_ff;
      s2_ox_ff   <= s1_ox_ff;
      s2_oy_ff   <= s1_oy_ff;
   end

   // coefficients are written from stage 2 so earlier pixels keep the old set
   nrcf_pkg::coef_type coef_ff [TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) coef_ff[i] <= '0;
      end else if (s2_load_ff && (32'(s2_idx_ff) < TAPS)) begin
         coef_ff[CI_W'(s2_idx_ff)] <= s2_coef_ff;
      end
   end

   logic signed [Q_W-1:0] s3_q_ff [3][MAX_KERNEL][MAX_KERNEL];
   logic                  s3_emit_ff;
   logic [X_W-1:0]        s3_ox_ff;
   logic [Y_W-1:0]        s3_oy_ff;

   for (genvar r = 0; r < MAX_KERNEL; r++) begin : g_tap_row
      for (genvar c = 0; c < MAX_KERNEL; c++) begin : g_tap_col
         nrcf_pkg::coef_type tap_coef;
         assign tap_coef = ((K_W'(r) < n_eff) && (K_W'(c) < n_eff))
                           ? coef_ff[CI_W'(r * 32'(n_eff) + c)] : '0;
         for (genvar ch = 0; ch < 3; ch++) begin : g_ch
            logic signed [PROD_W-1:0] prod;
            logic [PROD_W-1:0]        biased;
            assign prod   = $signed({1'b0, win_ff[r][c][ch*CW +: CW]}) * tap_coef;
            // truncate toward zero: bias negative products before the shift
            assign biased = prod + (prod[PROD_W-1] ? PROD_W'((1 << FRACW) - 1) : '0);
            always_ff @(posedge clock) begin
               s3_q_ff[ch][r][c] <= biased[FRACW +: Q_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_emit_ff <= 1'b0;
      else s3_emit_ff <= s2_emit_ff;
      s3_ox_ff <= s2_ox_ff;
      s3_oy_ff <= s2_oy_ff;
   end

   // ---------------- stage 3: row sums ----------------
   logic signed [ROW_W-1:0] s4_row_ff [3][MAX_KERNEL];
   logic                    s4_emit_ff;
   logic [X_W-1:0]          s4_ox_ff;
   logic [Y_W-1:0]          s4_oy_ff;

   for (genvar ch = 0; ch < 3; ch++) begin : g_rsum_ch
      for (genvar r = 0; r < MAX_KERNEL; r++) begin : g_rsum_row
         logic signed [ROW_W-1:0] acc;
         always_comb begin
            acc = '0;
            for (int c = 0; c < MAX_KERNEL; c++) acc = acc + ROW_W'(s3_q_ff[ch][r][c]);
         end
         always_ff @(posedge clock) begin
            s4_row_ff[ch][r] <= acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_emit_ff <= 1'b0;
      else s4_emit_ff <= s3_emit_ff;
      s4_ox_ff <= s3_ox_ff;
      s4_oy_ff <= s3_oy_ff;
   end

   // ---------------- stage 4: total, clamp ----------------
   logic [CW-1:0] clamped [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_total
      logic signed [SUM_W-1:0] total;
      always_comb begin
         total = '0;
         for (int r = 0; r < MAX_KERNEL; r++) total = total + SUM_W'(s4_row_ff[ch][r]);
      end
      assign clamped[ch] = total[SUM_W-1] ? '0 :
                           (|total[SUM_W-2:CW]) ? '1 : total[CW-1:0];
   end

   nrcf_pkg::rsp_word_type push_word;

   assign push_word = {PAD_W'(0), nrcf_pkg::ALPHA_OPAQUE, clamped[2], clamped[1], clamped[0],
                       XYW'(s4_oy_ff), XYW'(s4_ox_ff)};

   // ---------------- result queue ----------------
   nrcf_pkg::rsp_word_type fifo_ff [nrcf_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]         cnt_ff, cnt_in;
   logic                   pop;
   logic [USED_W-1:0]      used;

   assign pop    = rsp_tvalid && rsp_tready;
   assign cnt_in = cnt_ff + (PTR_W+1)'(s4_emit_ff) - (PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (s4_emit_ff) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_emit_ff) fifo_ff[wr_ptr_ff] <= push_word;
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = fifo_ff[rd_ptr_ff];

   // hold off requests while queued plus in-flight results could overflow
   assign used = USED_W'(cnt_ff) + USED_W'(s1_emit_ff) + USED_W'(s2_emit_ff)
               + USED_W'(s3_emit_ff) + USED_W'(s4_emit_ff);
   assign req_tready = !reset && (used < USED_W'(nrcf_pkg::FIFO_DEPTH));

endmodule

[rtl/nrcf_checker.sv]
// Port-level checks for the convolution filter, bound to the top level
`include "nxn_rgb_convolution_filter_defines.svh"

module nrcf_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [nrcf_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // every result is opaque
   `NRCF_ASSERT_NOW(a_alpha_opaque, clock, reset, rsp_tvalid, rsp_tdata[nrcf_pkg::RSP_ALPHA_LSB +: nrcf_pkg::CH_W] == nrcf_pkg::ALPHA_OPAQUE, "alpha not opaque")

   // backpressure only with results waiting
   `NRCF_ASSERT_NOW(a_ready_needs_backlog, clock, reset, !req_tready, rsp_tvalid, "ready low with empty queue")

   // ready can only drop in a cycle with no word taken
   `NRCF_ASSERT_NOW(a_ready_fall_no_pop, clock, reset, $fell(req_tready), $past(!(rsp_tvalid && rsp_tready)), "ready fell after a pop")

   // hold a stalled result
   `NRCF_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result withdrawn")

   `NRCF_ASSERT_NEXT(a_rsp_data_holds, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "stalled result changed")

endmodule

bind nxn_rgb_convolution_filter nrcf_checker u_nrcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
